// ----- rtl/ffs_pkg.sv -----
// Shared widths, codes and handshake types for the flipbook frame sequencer.
package ffs_pkg;

    localparam int ACC_W     = 32;   // time accumulator, 1/256 time unit per lsb
    localparam int FRAME_W   = 12;
    localparam int COUNT_W   = 13;   // frame count, up to 4096
    localparam int ABS_W     = 13;   // absolute cell index, first cell plus frame
    localparam int WRAP_W    = 25;   // frame plus advance count before the wrap
    localparam int GRID_W    = 16;
    localparam int SIDE_W    = 8;
    localparam int FIRST_W   = 12;
    localparam int LIMIT_W   = 13;
    localparam int SPEED_W   = 11;
    localparam int OSIDE_W   = 7;
    localparam int KIND_W    = 2;
    localparam int STEPS_W   = 6;
    localparam int CFG_IDX_W = 3;
    localparam int OP_W      = 4;

    localparam logic [GRID_W-1:0] MAX_FRAMES = 16'd4096;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd1;
    localparam logic [KIND_W-1:0] KIND_PLAY    = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SEEK    = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_AUTO   = 3'd7;

    typedef logic [OP_W-1:0] t_op;

    // datapath operations
    localparam t_op OP_NONE     = 4'd0;
    localparam t_op OP_CAPTURE  = 4'd1;
    localparam t_op OP_GRID     = 4'd2;
    localparam t_op OP_COUNT    = 4'd3;
    localparam t_op OP_PROD     = 4'd4;
    localparam t_op OP_SUM      = 4'd5;
    localparam t_op OP_DIV_TIME = 4'd6;
    localparam t_op OP_ADVANCE  = 4'd7;
    localparam t_op OP_NEED_MUL = 4'd8;
    localparam t_op OP_NEED_SUB = 4'd9;
    localparam t_op OP_DIV_WRAP = 4'd10;
    localparam t_op OP_WRAP     = 4'd11;
    localparam t_op OP_MISC     = 4'd12;
    localparam t_op OP_DIV_CELL = 4'd13;
    localparam t_op OP_CELL     = 4'd14;
    localparam t_op OP_EMIT     = 4'd15;

    typedef struct packed {
        t_op op;
    } t_dp_cmd;

    typedef struct packed {
        logic is_tick;
        logic tick_go;
        logic n_zero;
        logic loop;
        logic beyond;
        logic stop_now;
        logic div_done;
    } t_dp_sts;

    typedef struct packed {
        logic               start;
        logic [STEPS_W-1:0] steps;
    } t_div_ctl;

endpackage

// ----- rtl/ffs_div.sv -----
// Restoring divider, one quotient bit per cycle, dividend taken from the top bit down.
module ffs_div #(
    parameter int DIV_W = 28
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  ffs_pkg::t_div_ctl           i_ctl,
    input  logic [ffs_pkg::ACC_W-1:0]   i_dividend,
    input  logic [DIV_W-1:0]            i_divisor,
    output logic                        o_done,
    output logic [ffs_pkg::ACC_W-1:0]   o_quot,
    output logic [DIV_W-1:0]            o_rem
);

    logic                          r_busy;
    logic                          r_done;
    logic [ffs_pkg::STEPS_W-1:0]   r_cnt;
    logic [ffs_pkg::ACC_W-1:0]     r_q;
    logic [DIV_W-1:0]              r_rem;
    logic [DIV_W-1:0]              r_divisor;

    logic [DIV_W:0]                w_trial;
    logic                          w_ge;
    logic [DIV_W:0]                w_diff;

    assign w_trial = {r_rem, r_q[ffs_pkg::ACC_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_divisor};
    assign w_diff  = w_trial - {1'b0, r_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == ffs_pkg::STEPS_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_q       <= i_dividend;
            r_rem     <= '0;
            r_divisor <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[ffs_pkg::ACC_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DIV_W-1:0] : w_trial[DIV_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;
    assign o_rem  = r_rem;

`ifndef SYNTHESIS
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.start |-> !r_busy)
        else $error("divider started while busy");
`endif

endmodule

// ----- rtl/ffs_dpath.sv -----
// Datapath: registers, frame count, accumulator arithmetic, divider and result register.
module ffs_dpath #(
    parameter int GRID_SIDE_MAX = 128,
    parameter int TIME_BITS     = 20,
    parameter int CFG_W         = 20
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ffs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_W-1:0]                 i_cfg_data,
    input  logic [ffs_pkg::KIND_W-1:0]       i_kind,
    input  logic [TIME_BITS-1:0]             i_elapsed,
    input  logic [ffs_pkg::FRAME_W-1:0]      i_seek_frame,
    input  logic                             i_play_value,
    input  ffs_pkg::t_dp_cmd                 i_cmd,
    output ffs_pkg::t_dp_sts                 o_sts,
    output logic [ffs_pkg::FRAME_W-1:0]      o_frame_index,
    output logic [ffs_pkg::OSIDE_W-1:0]      o_cell_column,
    output logic [ffs_pkg::OSIDE_W-1:0]      o_cell_row,
    output logic                             o_is_playing,
    output logic                             o_finished,
    output logic                             o_frame_changed
);

    localparam int PER_W  = TIME_BITS + 8;
    localparam int PROD_W = TIME_BITS + ffs_pkg::SPEED_W;
    localparam int SUM_W  = (PROD_W > ffs_pkg::ACC_W) ? PROD_W + 1 : ffs_pkg::ACC_W + 1;
    localparam int EXT_W  = (PER_W > ffs_pkg::ACC_W) ? PER_W : ffs_pkg::ACC_W;
    localparam logic [8:0] SIDE_CAP = 9'(GRID_SIDE_MAX);

    // configuration
    logic [ffs_pkg::SIDE_W-1:0]  r_rows, r_cols;
    logic [ffs_pkg::FIRST_W-1:0] r_first;
    logic [ffs_pkg::LIMIT_W-1:0] r_limit;
    logic [TIME_BITS-1:0]        r_period;
    logic [ffs_pkg::SPEED_W-1:0] r_speed;
    logic                        r_loop, r_auto;

    // animation state
    logic [ffs_pkg::ACC_W-1:0]   r_time_acc;
    logic [ffs_pkg::FRAME_W-1:0] r_frame;
    logic                        r_playing;
    logic                        r_fin, r_changed;

    // item and working registers
    logic [ffs_pkg::KIND_W-1:0]  r_kind;
    logic [TIME_BITS-1:0]        r_elapsed;
    logic [ffs_pkg::FRAME_W-1:0] r_seek;
    logic                        r_pv;
    logic [ffs_pkg::GRID_W-1:0]  r_grid;
    logic [ffs_pkg::COUNT_W-1:0] r_maxf;
    logic [PROD_W-1:0]           r_prod;
    logic [ffs_pkg::ACC_W-1:0]   r_acc;
    logic [ffs_pkg::COUNT_W-1:0] r_need;
    logic [ffs_pkg::ACC_W-1:0]   r_nprod;
    logic [ffs_pkg::OSIDE_W-1:0] r_col, r_row;

    // result register
    logic [ffs_pkg::FRAME_W-1:0] r_o_frame;
    logic [ffs_pkg::OSIDE_W-1:0] r_o_col, r_o_row;
    logic                        r_o_playing, r_o_fin, r_o_changed;

    logic [ffs_pkg::SIDE_W-1:0]  w_rcap, w_ccap;
    logic [PER_W-1:0]            w_per;
    logic [EXT_W-1:0]            w_per_ext;
    logic [ffs_pkg::ACC_W-1:0]   w_quot;
    logic [PER_W-1:0]            w_rem;
    logic [EXT_W-1:0]            w_rem_ext;
    logic                        w_div_done;
    logic [ffs_pkg::COUNT_W-1:0] w_last;
    logic [ffs_pkg::COUNT_W-1:0] w_frame_ext;
    logic                        w_beyond;
    logic [ffs_pkg::COUNT_W-1:0] w_need;
    logic                        w_stop_now;
    logic [SUM_W-1:0]            w_sum;
    logic [ffs_pkg::ACC_W-1:0]   w_sat;
    logic [ffs_pkg::COUNT_W-1:0] w_count;
    logic [ffs_pkg::WRAP_W-1:0]  w_wrap;
    logic [ffs_pkg::FRAME_W-1:0] w_seek_t;
    logic [ffs_pkg::FRAME_W-1:0] w_cell_f;
    logic [ffs_pkg::ABS_W-1:0]   w_abs;
    ffs_pkg::t_div_ctl           w_div_ctl;
    logic [ffs_pkg::ACC_W-1:0]   w_dividend;
    logic [PER_W-1:0]            w_divisor;

    assign w_rcap = ({1'b0, r_rows} > SIDE_CAP) ? SIDE_CAP[ffs_pkg::SIDE_W-1:0] : r_rows;
    assign w_ccap = ({1'b0, r_cols} > SIDE_CAP) ? SIDE_CAP[ffs_pkg::SIDE_W-1:0] : r_cols;

    assign w_per     = {r_period, 8'd0};
    assign w_per_ext = EXT_W'(w_per);
    assign w_rem_ext = EXT_W'(w_rem);

    assign w_last      = r_maxf - 1'b1;
    assign w_frame_ext = {1'b0, r_frame};
    assign w_beyond    = w_frame_ext >= r_maxf;
    assign w_need      = r_maxf - w_frame_ext;
    assign w_stop_now  = w_quot >= ffs_pkg::ACC_W'(w_need);

    // accumulator plus product, saturating at the top of the accumulator
    assign w_sum = SUM_W'(r_time_acc) + SUM_W'(r_prod);
    assign w_sat = (|w_sum[SUM_W-1:ffs_pkg::ACC_W]) ? '1 : w_sum[ffs_pkg::ACC_W-1:0];

    // usable frame count from the registered grid size
    always_comb begin
        logic [ffs_pkg::GRID_W-1:0] avail;
        avail = r_grid - ffs_pkg::GRID_W'(r_first);
        if (ffs_pkg::GRID_W'(r_first) >= r_grid) begin
            w_count = '0;
        end else begin
            if (r_limit != '0 && ffs_pkg::GRID_W'(r_limit) < avail) begin
                avail = ffs_pkg::GRID_W'(r_limit);
            end
            if (avail > ffs_pkg::MAX_FRAMES) begin
                avail = ffs_pkg::MAX_FRAMES;
            end
            w_count = avail[ffs_pkg::COUNT_W-1:0];
        end
    end

    // beyond the end: one period is spent on reaching frame 0
    assign w_wrap = w_beyond ? (w_quot[ffs_pkg::WRAP_W-1:0] - 1'b1)
                             : (w_quot[ffs_pkg::WRAP_W-1:0] + ffs_pkg::WRAP_W'(r_frame));

    assign w_seek_t = (r_maxf == '0) ? '0
                    : ((ffs_pkg::COUNT_W'(r_seek) > w_last) ? w_last[ffs_pkg::FRAME_W-1:0]
                                                            : r_seek);

    assign w_cell_f = w_beyond ? w_last[ffs_pkg::FRAME_W-1:0] : r_frame;
    assign w_abs    = ffs_pkg::ABS_W'(r_first) + ffs_pkg::ABS_W'(w_cell_f);

    // divider operands, dividend aligned to the top so only the used bits are stepped
    always_comb begin
        w_div_ctl.start = 1'b0;
        w_div_ctl.steps = '0;
        w_dividend      = '0;
        w_divisor       = '0;
        unique case (i_cmd.op)
            ffs_pkg::OP_DIV_TIME: begin
                w_div_ctl.start = 1'b1;
                w_div_ctl.steps = ffs_pkg::STEPS_W'(ffs_pkg::ACC_W);
                w_dividend      = r_acc;
                w_divisor       = w_per;
            end
            ffs_pkg::OP_DIV_WRAP: begin
                w_div_ctl.start = 1'b1;
                w_div_ctl.steps = ffs_pkg::STEPS_W'(ffs_pkg::WRAP_W);
                w_dividend      = {w_wrap, {(ffs_pkg::ACC_W - ffs_pkg::WRAP_W){1'b0}}};
                w_divisor       = PER_W'(r_maxf);
            end
            ffs_pkg::OP_DIV_CELL: begin
                w_div_ctl.start = 1'b1;
                w_div_ctl.steps = ffs_pkg::STEPS_W'(ffs_pkg::ABS_W);
                w_dividend      = {w_abs, {(ffs_pkg::ACC_W - ffs_pkg::ABS_W){1'b0}}};
                w_divisor       = PER_W'(w_ccap);
            end
            default: begin
            end
        endcase
    end

    ffs_div #(
        .DIV_W (PER_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_div_ctl),
        .i_dividend (w_dividend),
        .i_divisor  (w_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    // configuration and animation state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows     <= 8'd1;
            r_cols     <= 8'd1;
            r_first    <= '0;
            r_limit    <= '0;
            r_period   <= '0;
            r_speed    <= 11'd256;
            r_loop     <= 1'b1;
            r_auto     <= 1'b1;
            r_time_acc <= '0;
            r_frame    <= '0;
            r_playing  <= 1'b1;
            r_fin      <= 1'b0;
            r_changed  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    ffs_pkg::CFG_ROWS:   r_rows   <= i_cfg_data[ffs_pkg::SIDE_W-1:0];
                    ffs_pkg::CFG_COLS:   r_cols   <= i_cfg_data[ffs_pkg::SIDE_W-1:0];
                    ffs_pkg::CFG_FIRST:  r_first  <= i_cfg_data[ffs_pkg::FIRST_W-1:0];
                    ffs_pkg::CFG_LIMIT:  r_limit  <= i_cfg_data[ffs_pkg::LIMIT_W-1:0];
                    ffs_pkg::CFG_PERIOD: r_period <= i_cfg_data[TIME_BITS-1:0];
                    ffs_pkg::CFG_SPEED:  r_speed  <= i_cfg_data[ffs_pkg::SPEED_W-1:0];
                    ffs_pkg::CFG_LOOP:   r_loop   <= i_cfg_data[0];
                    ffs_pkg::CFG_AUTO:   r_auto   <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            unique case (i_cmd.op)
                ffs_pkg::OP_CAPTURE: begin
                    r_fin     <= 1'b0;
                    r_changed <= 1'b0;
                end
                ffs_pkg::OP_ADVANCE: begin
                    if (w_quot == '0) begin
                        r_time_acc <= r_acc;
                    end else begin
                        r_changed <= 1'b1;
                        if (r_loop) begin
                            r_time_acc <= w_rem_ext[ffs_pkg::ACC_W-1:0];
                        end else if (w_beyond) begin
                            r_frame    <= w_last[ffs_pkg::FRAME_W-1:0];
                            r_playing  <= 1'b0;
                            r_fin      <= 1'b1;
                            r_time_acc <= r_acc - w_per_ext[ffs_pkg::ACC_W-1:0];
                        end else if (w_stop_now) begin
                            r_frame   <= w_last[ffs_pkg::FRAME_W-1:0];
                            r_playing <= 1'b0;
                            r_fin     <= 1'b1;
                        end else begin
                            r_frame    <= r_frame + w_quot[ffs_pkg::FRAME_W-1:0];
                            r_time_acc <= w_rem_ext[ffs_pkg::ACC_W-1:0];
                        end
                    end
                end
                ffs_pkg::OP_NEED_SUB: r_time_acc <= r_acc - r_nprod;
                ffs_pkg::OP_WRAP:     r_frame    <= w_rem[ffs_pkg::FRAME_W-1:0];
                ffs_pkg::OP_MISC: begin
                    unique case (r_kind)
                        ffs_pkg::KIND_RESTART: begin
                            r_frame    <= '0;
                            r_time_acc <= '0;
                            r_playing  <= r_auto;
                            r_changed  <= r_frame != '0;
                        end
                        ffs_pkg::KIND_PLAY: r_playing <= r_pv;
                        ffs_pkg::KIND_SEEK: begin
                            r_frame   <= w_seek_t;
                            r_changed <= w_seek_t != r_frame;
                        end
                        default: begin
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end
    end

    // working registers and result register
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            ffs_pkg::OP_CAPTURE: begin
                r_kind    <= i_kind;
                r_elapsed <= i_elapsed;
                r_seek    <= i_seek_frame;
                r_pv      <= i_play_value;
            end
            ffs_pkg::OP_GRID:     r_grid  <= ffs_pkg::GRID_W'(w_rcap) * ffs_pkg::GRID_W'(w_ccap);
            ffs_pkg::OP_COUNT:    r_maxf  <= w_count;
            ffs_pkg::OP_PROD:     r_prod  <= PROD_W'(r_elapsed) * PROD_W'(r_speed);
            ffs_pkg::OP_SUM:      r_acc   <= w_sat;
            ffs_pkg::OP_ADVANCE:  r_need  <= w_need;
            ffs_pkg::OP_NEED_MUL: r_nprod <= ffs_pkg::ACC_W'(r_need)
                                             * w_per_ext[ffs_pkg::ACC_W-1:0];
            ffs_pkg::OP_CELL: begin
                if (r_maxf == '0) begin
                    r_col <= '0;
                    r_row <= '0;
                end else begin
                    r_col <= w_rem[ffs_pkg::OSIDE_W-1:0];
                    r_row <= w_quot[ffs_pkg::OSIDE_W-1:0];
                end
            end
            ffs_pkg::OP_EMIT: begin
                r_o_frame   <= r_frame;
                r_o_col     <= r_col;
                r_o_row     <= r_row;
                r_o_playing <= r_playing;
                r_o_fin     <= r_fin;
                r_o_changed <= r_changed;
            end
            default: begin
            end
        endcase
    end

    assign o_sts.is_tick  = r_kind == ffs_pkg::KIND_TICK;
    assign o_sts.tick_go  = r_playing && (r_maxf > ffs_pkg::COUNT_W'(1))
                            && (r_period != '0) && (r_speed != '0);
    assign o_sts.n_zero   = w_quot == '0;
    assign o_sts.loop     = r_loop;
    assign o_sts.beyond   = w_beyond;
    assign o_sts.stop_now = w_stop_now;
    assign o_sts.div_done = w_div_done;

    assign o_frame_index   = r_o_frame;
    assign o_cell_column   = r_o_col;
    assign o_cell_row      = r_o_row;
    assign o_is_playing    = r_o_playing;
    assign o_finished      = r_o_fin;
    assign o_frame_changed = r_o_changed;

`ifndef SYNTHESIS
    a_fin_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin |-> !r_playing)
        else $error("finished flagged while still playing");
`endif

endmodule

// ----- rtl/ffs_ctrl.sv -----
// Controller: sequences one item at a time through the datapath and owns both handshakes.
module ffs_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    input  ffs_pkg::t_dp_sts  i_sts,
    output ffs_pkg::t_dp_cmd  o_cmd
);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_GRID   = 5'd1;
    localparam logic [4:0] ST_COUNT  = 5'd2;
    localparam logic [4:0] ST_DECIDE = 5'd3;
    localparam logic [4:0] ST_PROD   = 5'd4;
    localparam logic [4:0] ST_SUM    = 5'd5;
    localparam logic [4:0] ST_DIVT   = 5'd6;
    localparam logic [4:0] ST_DIVT_W = 5'd7;
    localparam logic [4:0] ST_ADV    = 5'd8;
    localparam logic [4:0] ST_NMUL   = 5'd9;
    localparam logic [4:0] ST_NSUB   = 5'd10;
    localparam logic [4:0] ST_DIVW   = 5'd11;
    localparam logic [4:0] ST_DIVW_W = 5'd12;
    localparam logic [4:0] ST_WRAP   = 5'd13;
    localparam logic [4:0] ST_MISC   = 5'd14;
    localparam logic [4:0] ST_DIVC   = 5'd15;
    localparam logic [4:0] ST_DIVC_W = 5'd16;
    localparam logic [4:0] ST_CELL   = 5'd17;
    localparam logic [4:0] ST_EMIT   = 5'd18;

    logic [4:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd.op    = ffs_pkg::OP_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = ffs_pkg::OP_CAPTURE;
                    n_state  = ST_GRID;
                end
            end
            ST_GRID: begin
                o_cmd.op = ffs_pkg::OP_GRID;
                n_state  = ST_COUNT;
            end
            ST_COUNT: begin
                o_cmd.op = ffs_pkg::OP_COUNT;
                n_state  = ST_DECIDE;
            end
            ST_DECIDE: begin
                priority if (!i_sts.is_tick) n_state = ST_MISC;
                else if (i_sts.tick_go)      n_state = ST_PROD;
                else                         n_state = ST_DIVC;
            end
            ST_PROD: begin
                o_cmd.op = ffs_pkg::OP_PROD;
                n_state  = ST_SUM;
            end
            ST_SUM: begin
                o_cmd.op = ffs_pkg::OP_SUM;
                n_state  = ST_DIVT;
            end
            ST_DIVT: begin
                o_cmd.op = ffs_pkg::OP_DIV_TIME;
                n_state  = ST_DIVT_W;
            end
            ST_DIVT_W: begin
                if (i_sts.div_done) n_state = ST_ADV;
            end
            ST_ADV: begin
                o_cmd.op = ffs_pkg::OP_ADVANCE;
                priority if (i_sts.n_zero) n_state = ST_DIVC;
                else if (i_sts.loop)       n_state = ST_DIVW;
                else if (i_sts.beyond)     n_state = ST_DIVC;
                else if (i_sts.stop_now)   n_state = ST_NMUL;
                else                       n_state = ST_DIVC;
            end
            ST_NMUL: begin
                o_cmd.op = ffs_pkg::OP_NEED_MUL;
                n_state  = ST_NSUB;
            end
            ST_NSUB: begin
                o_cmd.op = ffs_pkg::OP_NEED_SUB;
                n_state  = ST_DIVC;
            end
            ST_DIVW: begin
                o_cmd.op = ffs_pkg::OP_DIV_WRAP;
                n_state  = ST_DIVW_W;
            end
            ST_DIVW_W: begin
                if (i_sts.div_done) n_state = ST_WRAP;
            end
            ST_WRAP: begin
                o_cmd.op = ffs_pkg::OP_WRAP;
                n_state  = ST_DIVC;
            end
            ST_MISC: begin
                o_cmd.op = ffs_pkg::OP_MISC;
                n_state  = ST_DIVC;
            end
            ST_DIVC: begin
                o_cmd.op = ffs_pkg::OP_DIV_CELL;
                n_state  = ST_DIVC_W;
            end
            ST_DIVC_W: begin
                if (i_sts.div_done) n_state = ST_CELL;
            end
            ST_CELL: begin
                o_cmd.op = ffs_pkg::OP_CELL;
                n_state  = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_free) begin
                    o_cmd.op    = ffs_pkg::OP_EMIT;
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = r_state != ST_IDLE;
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && i_in_valid) |=> (r_state == ST_GRID))
        else $error("accepted beat did not start the sequence");

    a_valid_from_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_EMIT))
        else $error("result raised outside the emit step");
`endif

endmodule

// ----- rtl/flipbook_frame_sequencer.sv -----
// Top level of the flipbook frame sequencer: controller, datapath and ports.
//
// Usage: items arrive as beats on the input channel (i_in_valid / o_in_stall)
// carrying kind, elapsed, seek_frame and play_value; each item gives exactly one
// result beat on the output channel (o_out_valid / i_out_stall) with the frame,
// the column and row of its sprite-sheet cell and the playing, finished and
// frame-changed flags. Registers are written through i_cfg_we / i_cfg_idx /
// i_cfg_data; the user must write them only while no item is in flight; the
// block itself does not enforce it. Throughput: one item at a time; the next
// beat is taken in the idle state that follows loading the result. A looping
// tick that advances runs time (32 steps), wrap (25) and cell (13) divides on
// the shared one-bit-per-cycle divider; other ticks past the halt check run the
// time and cell divides (plus a need correction if a non-looping run stops
// there); a halted tick, restart, set-playing or seek runs only the cell divide.
// Stall: the result sits in an output register; a new input beat is taken while
// it waits, and the item then holds in its final step until the result is taken.
// Reset (synchronous, active low) loads the register defaults, frame 0, empty
// accumulator, playing set, and empties the output register.
module flipbook_frame_sequencer #(
    parameter int GRID_SIDE_MAX = 128,
    parameter int TIME_BITS     = 20
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write port
    input  logic                               i_cfg_we,
    input  logic [ffs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [((TIME_BITS > ffs_pkg::LIMIT_W) ? TIME_BITS : ffs_pkg::LIMIT_W)-1:0]
                                               i_cfg_data,
    // input channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [ffs_pkg::KIND_W-1:0]         i_kind,
    input  logic [TIME_BITS-1:0]               i_elapsed,
    input  logic [ffs_pkg::FRAME_W-1:0]        i_seek_frame,
    input  logic                               i_play_value,
    // output channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [ffs_pkg::FRAME_W-1:0]        o_frame_index,
    output logic [ffs_pkg::OSIDE_W-1:0]        o_cell_column,
    output logic [ffs_pkg::OSIDE_W-1:0]        o_cell_row,
    output logic                               o_is_playing,
    output logic                               o_finished,
    output logic                               o_frame_changed
);

    // widest register sets the write data width
    localparam int CFG_W = (TIME_BITS > ffs_pkg::LIMIT_W) ? TIME_BITS : ffs_pkg::LIMIT_W;

    ffs_pkg::t_dp_cmd w_cmd;
    ffs_pkg::t_dp_sts w_sts;

    ffs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    ffs_dpath #(
        .GRID_SIDE_MAX (GRID_SIDE_MAX),
        .TIME_BITS     (TIME_BITS),
        .CFG_W         (CFG_W)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_kind          (i_kind),
        .i_elapsed       (i_elapsed),
        .i_seek_frame    (i_seek_frame),
        .i_play_value    (i_play_value),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .o_frame_index   (o_frame_index),
        .o_cell_column   (o_cell_column),
        .o_cell_row      (o_cell_row),
        .o_is_playing    (o_is_playing),
        .o_finished      (o_finished),
        .o_frame_changed (o_frame_changed)
    );

endmodule
